@@ sv/lkv_pkg.sv @@
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int MODE_WIDTH = 2;
  localparam int CAP_WIDTH  = 5;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

  // request operations
  localparam logic [MODE_WIDTH-1:0] MODE_GET = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_SET = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_DEL = 2'd2;

  // result codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOTFOUND = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UNLINK,
    S_INSERT,
    S_PUSH,
    S_PUSH2,
    S_FINISH
  } state_t;

endpackage

@@ sv/lkv_if.sv @@
`timescale 1ns / 1ps
interface lkv_req_if #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [lkv_pkg::MODE_WIDTH-1:0] mode;
  logic [KEY_WIDTH-1:0]           key;
  logic [VALUE_WIDTH-1:0]         value;
  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lkv_rsp_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [VALUE_WIDTH-1:0] read_value;
  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

interface lkv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lkv_pkg::CAP_WIDTH-1:0] capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

@@ sv/lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Payload                  Notes
// req      in   mode, key, value         get / set / delete request
// rsp      out  status, read_value       one result per request, registered
// cfg      in   capacity                 write only while idle
//
// A request runs a linear key scan of the key memory (one entry per cycle,
// one read port), then the link memory steps (unlink, insert, push).
// After reset a clearing pass invalidates the key memory; requests are
// held off meanwhile, configuration writes are taken.
// A result waiting in the output register does not block the next request;
// only a second finished result stalls until rsp is taken.
module lru_key_value_cache_core #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  lkv_req_if.sink     req,
  lkv_rsp_if.source   rsp,
  lkv_cfg_if.sink     cfg
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = KEY_WIDTH + 1;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [IW:0]   DEPTH_N = (IW + 1)'(DEPTH);

  // memories: {valid, key}, value, and the two recency links
  logic [KW-1:0]          kmem [DEPTH];
  logic [VALUE_WIDTH-1:0] vmem [DEPTH];
  logic [IW-1:0]          nmem [DEPTH];
  logic [IW-1:0]          omem [DEPTH];

  logic                   k_we, k_re, v_we, v_re, l_re, n_we, o_we;
  logic [IW-1:0]          k_waddr, k_raddr, v_addr, l_raddr, n_waddr, o_waddr;
  logic [KW-1:0]          k_wdata, k_q;
  logic [VALUE_WIDTH-1:0] v_q;
  logic [IW-1:0]          n_wdata, o_wdata, n_q, o_q;

  lkv_pkg::state_t state, state_next;

  logic [lkv_pkg::CAP_WIDTH-1:0]  capacity;
  logic [lkv_pkg::MODE_WIDTH-1:0] mode_r;
  logic [KEY_WIDTH-1:0]           key_r;
  logic [VALUE_WIDTH-1:0]         value_r;
  logic [IW:0]                    cnt;
  logic                           cmp_v;
  logic [IW-1:0]                  cmp_idx;
  logic                           hit, free_f;
  logic [IW-1:0]                  hit_slot, free_slot, tgt, ins_slot;
  logic [IW-1:0]                  mr, lr;
  logic [CW-1:0]                  count;
  logic                           push_empty;
  logic                           status_r, rd_sel;
  logic                           out_valid, out_status;
  logic [VALUE_WIDTH-1:0]         out_value;

  logic evict, can_finish, scan_done, cap_full;
  logic [IW-1:0] evict_slot;

  // memory ports
  always_ff @(posedge clk) begin
    if (k_we) kmem[k_waddr] <= k_wdata;
    if (k_re) k_q <= kmem[k_raddr];
  end
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_addr] <= value_r;
    if (v_re) v_q <= vmem[v_addr];
  end
  always_ff @(posedge clk) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    if (l_re) n_q <= nmem[l_raddr];
  end
  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    if (l_re) o_q <= omem[l_raddr];
  end

  // capacity 0 acts as 1, above DEPTH acts as DEPTH
  assign cap_full = (32'(count) >= 32'(capacity)) || (32'(count) >= 32'(DEPTH));
  assign evict = (count != '0) && cap_full;
  assign evict_slot = (free_f && (free_slot < lr)) ? free_slot : lr;
  assign scan_done = cmp_v && (cmp_idx == LAST);
  assign can_finish = !out_valid || rsp.ready;

  assign req.ready = (state == lkv_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.read_value = out_value;

  // sequencer: next state and memory controls
  always_comb begin
    state_next = state;
    k_we = 1'b0; k_re = 1'b0; k_waddr = cnt[IW-1:0]; k_raddr = cnt[IW-1:0];
    k_wdata = '0;
    v_we = 1'b0; v_re = 1'b0; v_addr = hit_slot;
    l_re = 1'b0; l_raddr = hit_slot;
    n_we = 1'b0; n_waddr = tgt; n_wdata = tgt;
    o_we = 1'b0; o_waddr = tgt; o_wdata = tgt;
    unique case (state)
      lkv_pkg::S_CLEAR: begin
        k_we = 1'b1;
        if (cnt[IW-1:0] == LAST) state_next = lkv_pkg::S_IDLE;
      end
      lkv_pkg::S_IDLE: begin
        if (req.valid) state_next = lkv_pkg::S_SCAN;
      end
      lkv_pkg::S_SCAN: begin
        k_re = (cnt < DEPTH_N);
        if (scan_done) state_next = lkv_pkg::S_DECIDE;
      end
      lkv_pkg::S_DECIDE: begin
        state_next = lkv_pkg::S_FINISH;
        if (mode_r == lkv_pkg::MODE_GET && hit) begin
          v_re = 1'b1;
          if (hit_slot != mr) begin
            l_re = 1'b1;
            state_next = lkv_pkg::S_UNLINK;
          end
        end else if (mode_r == lkv_pkg::MODE_SET && hit) begin
          v_we = 1'b1;
          if (hit_slot != mr) begin
            l_re = 1'b1;
            state_next = lkv_pkg::S_UNLINK;
          end
        end else if (mode_r == lkv_pkg::MODE_SET && evict) begin
          l_re = 1'b1; l_raddr = lr;
          k_we = 1'b1; k_waddr = lr;
          state_next = lkv_pkg::S_UNLINK;
        end else if (mode_r == lkv_pkg::MODE_SET && free_f) begin
          state_next = lkv_pkg::S_INSERT;
        end else if (mode_r == lkv_pkg::MODE_DEL && hit) begin
          l_re = 1'b1;
          k_we = 1'b1; k_waddr = hit_slot;
          state_next = lkv_pkg::S_UNLINK;
        end
      end
      lkv_pkg::S_UNLINK: begin
        // older[newer] = older, newer[older] = newer, unless at an end
        if (tgt != mr) begin
          o_we = 1'b1; o_waddr = n_q; o_wdata = o_q;
        end
        if (tgt != lr) begin
          n_we = 1'b1; n_waddr = o_q; n_wdata = n_q;
        end
        if (mode_r == lkv_pkg::MODE_DEL) state_next = lkv_pkg::S_FINISH;
        else if (!hit) state_next = lkv_pkg::S_INSERT;
        else state_next = lkv_pkg::S_PUSH;
      end
      lkv_pkg::S_INSERT: begin
        k_we = 1'b1; k_waddr = ins_slot; k_wdata = {1'b1, key_r};
        v_we = 1'b1; v_addr = ins_slot;
        state_next = lkv_pkg::S_PUSH;
      end
      lkv_pkg::S_PUSH: begin
        if (push_empty) begin
          n_we = 1'b1; o_we = 1'b1;
          state_next = lkv_pkg::S_FINISH;
        end else begin
          o_we = 1'b1; o_wdata = mr;
          n_we = 1'b1; n_waddr = mr;
          state_next = lkv_pkg::S_PUSH2;
        end
      end
      lkv_pkg::S_PUSH2: begin
        n_we = 1'b1;
        state_next = lkv_pkg::S_FINISH;
      end
      lkv_pkg::S_FINISH: begin
        if (can_finish) state_next = lkv_pkg::S_IDLE;
      end
      default: state_next = lkv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lkv_pkg::S_CLEAR;
    else state <= state_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) capacity <= lkv_pkg::CAP_RESET;
    else if (cfg.valid) capacity <= cfg.capacity;
  end

  // list ends and count
  always_ff @(posedge clk) begin
    if (rst) begin
      mr <= '0;
      lr <= '0;
      count <= '0;
    end else begin
      unique case (state)
        lkv_pkg::S_UNLINK: begin
          if (tgt == mr) mr <= o_q;
          if (tgt == lr) lr <= n_q;
          if (mode_r == lkv_pkg::MODE_DEL || !hit) count <= count - 1'b1;
        end
        lkv_pkg::S_INSERT: count <= count + 1'b1;
        lkv_pkg::S_PUSH: begin
          mr <= tgt;
          if (push_empty) lr <= tgt;
        end
        default: ;
      endcase
    end
  end

  // scan counter and request working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      cmp_v <= 1'b0;
    end else begin
      unique case (state)
        lkv_pkg::S_CLEAR: cnt <= cnt + 1'b1;
        lkv_pkg::S_IDLE: begin
          cnt <= '0;
          cmp_v <= 1'b0;
        end
        lkv_pkg::S_SCAN: begin
          cmp_v <= (cnt < DEPTH_N);
          cmp_idx <= cnt[IW-1:0];
          if (cnt < DEPTH_N) cnt <= cnt + 1'b1;
        end
        default: cmp_v <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lkv_pkg::S_IDLE: begin
        mode_r <= req.mode;
        key_r <= req.key;
        value_r <= req.value;
        hit <= 1'b0;
        free_f <= 1'b0;
      end
      lkv_pkg::S_SCAN: begin
        if (cmp_v && k_q[KW-1] && (k_q[KEY_WIDTH-1:0] == key_r)) begin
          hit <= 1'b1;
          hit_slot <= cmp_idx;
        end
        if (cmp_v && !k_q[KW-1] && !free_f) begin
          free_f <= 1'b1;
          free_slot <= cmp_idx;
        end
      end
      lkv_pkg::S_DECIDE: begin
        status_r <= lkv_pkg::STATUS_NOTFOUND;
        rd_sel <= 1'b0;
        tgt <= hit_slot;
        push_empty <= 1'b0;
        if (mode_r == lkv_pkg::MODE_SET) begin
          status_r <= lkv_pkg::STATUS_OK;
          if (!hit) begin
            tgt <= lr;
            ins_slot <= evict ? evict_slot : free_slot;
          end
        end else if (hit && (mode_r == lkv_pkg::MODE_GET || mode_r == lkv_pkg::MODE_DEL)) begin
          status_r <= lkv_pkg::STATUS_OK;
          rd_sel <= (mode_r == lkv_pkg::MODE_GET);
        end
      end
      lkv_pkg::S_INSERT: begin
        tgt <= ins_slot;
        push_empty <= (count == '0);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == lkv_pkg::S_FINISH && can_finish) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == lkv_pkg::S_FINISH && can_finish) begin
      out_status <= status_r;
      out_value <= rd_sel ? v_q : '0;
    end
  end

endmodule

@@ tb/tb_lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
module tb_lru_key_value_cache_core;

  localparam int DEPTH     = 16;
  localparam int IDLE_WAIT = 4 * DEPTH + 40;
  localparam int WDOG_MAX  = 4000;

  // mode code with no operation behind it
  localparam logic [lkv_pkg::MODE_WIDTH-1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic             status;
    logic [31:0]      read_value;
  } cache_rsp_t;

  // LRU cache predictor plus queue of expected responses
  class cache_scoreboard;
    logic [31:0] keys [DEPTH];
    logic [31:0] vals [DEPTH];
    bit          used [DEPTH];
    int          newer [DEPTH];
    int          older [DEPTH];
    int          mru, lru, count, cap;
    cache_rsp_t  pending [$];
    int          errors;

    function void clear();
      for (int i = 0; i < DEPTH; i++) begin
        used[i] = 0;
        newer[i] = 0;
        older[i] = 0;
      end
      mru = 0;
      lru = 0;
      count = 0;
      cap = lkv_pkg::CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [lkv_pkg::CAP_WIDTH-1:0] c);
      cap = c;
    endfunction

    function int lookup(logic [31:0] k);
      for (int i = 0; i < DEPTH; i++)
        if (used[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void unlink(int s);
      int nw, od;
      nw = newer[s];
      od = older[s];
      if (s == mru) mru = od;
      else older[nw] = od;
      if (s == lru) lru = nw;
      else newer[od] = nw;
    endfunction

    function void push_front(int s, bit empty);
      if (empty) begin
        mru = s;
        lru = s;
        newer[s] = s;
        older[s] = s;
      end else begin
        newer[mru] = s;
        older[s] = mru;
        newer[s] = s;
        mru = s;
      end
    endfunction

    function void touch(int s);
      if (s != mru) begin
        unlink(s);
        push_front(s, 0);
      end
    endfunction

    // apply one accepted request, queue its response
    function void note_request(logic [lkv_pkg::MODE_WIDTH-1:0] m, logic [31:0] k,
                               logic [31:0] v);
      int hit, limit, slot;
      cache_rsp_t r;
      hit = lookup(k);
      r.status = lkv_pkg::STATUS_NOTFOUND;
      r.read_value = '0;
      limit = (cap == 0) ? 1 : (cap > DEPTH ? DEPTH : cap);
      case (m)
        lkv_pkg::MODE_GET: begin
          if (hit >= 0) begin
            r.read_value = vals[hit];
            touch(hit);
            r.status = lkv_pkg::STATUS_OK;
          end
        end
        lkv_pkg::MODE_SET: begin
          r.status = lkv_pkg::STATUS_OK;
          if (hit >= 0) begin
            touch(hit);
            vals[hit] = v;
          end else begin
            if (count >= limit && count > 0) begin
              slot = lru;
              unlink(slot);
              used[slot] = 0;
              count--;
            end
            slot = -1;
            for (int i = 0; i < DEPTH; i++)
              if (!used[i] && slot < 0) slot = i;
            if (slot >= 0) begin
              keys[slot] = k;
              vals[slot] = v;
              used[slot] = 1;
              push_front(slot, count == 0);
              count++;
            end
          end
        end
        lkv_pkg::MODE_DEL: begin
          if (hit >= 0) begin
            unlink(hit);
            used[hit] = 0;
            if (count > 0) count--;
            r.status = lkv_pkg::STATUS_OK;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_response(logic st, logic [31:0] rv);
      cache_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response status=%0d read_value=%h", st, rv);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, st);
        errors++;
      end
      if (rv !== e.read_value) begin
        $error("read_value: expected %h actual %h", e.read_value, rv);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  lkv_req_if #(.KEY_WIDTH(32), .VALUE_WIDTH(32)) req ();
  lkv_rsp_if #(.VALUE_WIDTH(32)) rsp ();
  lkv_cfg_if cfg ();

  lru_key_value_cache_core #(.DEPTH(DEPTH), .KEY_WIDTH(32), .VALUE_WIDTH(32)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  cache_scoreboard sb;
  bit  quiet;        // no idling on either side
  int  stall_left;
  int  wdog;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // response side: random ready bursts, check on acceptance
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.read_value);
      if (quiet) begin
        rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 17) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // valid stays high into the next request unless a gap is taken
  task automatic send_request(logic [lkv_pkg::MODE_WIDTH-1:0] m, logic [31:0] k,
                              logic [31:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode  <= m;
    req.key   <= k;
    req.value <= v;
    do @(posedge clk); while (!req.ready);
    sb.note_request(m, k, v);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_WIDTH-1:0] c);
    drain();
    cfg.valid    <= 1'b1;
    cfg.capacity <= c;
    do @(posedge clk); while (!cfg.ready);
    sb.set_capacity(c);
    cfg.valid <= 1'b0;
  endtask

  // keys drawn from a small pool so hits and evictions happen often
  function automatic logic [31:0] pick_key(int pool);
    if ($urandom_range(0, 19) == 0) return $urandom();
    return 32'h5a00_0000 + $urandom_range(0, pool - 1);
  endfunction

  function automatic logic [lkv_pkg::MODE_WIDTH-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return lkv_pkg::MODE_GET;
    if (r < 80) return lkv_pkg::MODE_SET;
    if (r < 97) return lkv_pkg::MODE_DEL;
    return MODE_NONE;
  endfunction

  initial begin
    logic [lkv_pkg::CAP_WIDTH-1:0] caps [6];
    sb = new();
    sb.clear();
    quiet = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = lkv_pkg::MODE_GET;
    req.key = '0;
    req.value = '0;
    cfg.valid = 1'b0;
    cfg.capacity = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, each operation, unused mode, misses
    send_request(lkv_pkg::MODE_GET, 32'h0, 32'h0);
    send_request(lkv_pkg::MODE_SET, 32'h0, 32'hffff_ffff);
    send_request(lkv_pkg::MODE_SET, 32'hffff_ffff, 32'h0);
    send_request(lkv_pkg::MODE_GET, 32'h0, 32'h1234);
    send_request(lkv_pkg::MODE_GET, 32'hffff_ffff, 32'h0);
    send_request(lkv_pkg::MODE_SET, 32'h0, 32'ha5a5_5a5a);
    send_request(lkv_pkg::MODE_GET, 32'h0, 32'h0);
    send_request(MODE_NONE, 32'h0, 32'hffff_ffff);
    send_request(lkv_pkg::MODE_DEL, 32'h0, 32'h0);
    send_request(lkv_pkg::MODE_DEL, 32'h0, 32'h0);
    send_request(lkv_pkg::MODE_GET, 32'h0, 32'h0);
    // capacity 1: each new key evicts the last one
    write_capacity(5'd1);
    send_request(lkv_pkg::MODE_SET, 32'h1, 32'h11);
    send_request(lkv_pkg::MODE_SET, 32'h2, 32'h22);
    send_request(lkv_pkg::MODE_GET, 32'h1, 32'h0);
    send_request(lkv_pkg::MODE_GET, 32'h2, 32'h0);
    // capacity zero acts as one, above DEPTH acts as DEPTH
    write_capacity(5'd0);
    send_request(lkv_pkg::MODE_SET, 32'h3, 32'h33);
    send_request(lkv_pkg::MODE_GET, 32'h2, 32'h0);
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_request(lkv_pkg::MODE_SET, 32'h100 + i, i);
    send_request(lkv_pkg::MODE_GET, 32'h100, 32'h0);
    send_request(lkv_pkg::MODE_GET, 32'h102, 32'h0);
    // shrink below count
    write_capacity(5'd3);
    send_request(lkv_pkg::MODE_SET, 32'h200, 32'h1);
    send_request(lkv_pkg::MODE_GET, 32'h103, 32'h0);

    // pause until everything returned
    drain();

    // random phases at several capacities
    caps = '{5'd16, 5'd1, 5'd2, 5'd7, 5'd31, 5'd16};
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      for (int n = 0; n < 260; n++) begin
        if (ph == 5 && n > 180) quiet = 1'b1;
        send_request(pick_mode(), pick_key(ph == 4 ? 24 : 12), $urandom());
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
